@@ design/eretab_pkg.sv @@
// Shared types and constants for the epoch-retired evidence table.
// No dependencies; imported by the core.
package eretab_pkg;

    localparam logic [2:0] REQ_ADMIT      = 3'd0;
    localparam logic [2:0] REQ_STALE_IF   = 3'd1;
    localparam logic [2:0] REQ_MARK_STALE = 3'd2;
    localparam logic [2:0] REQ_RETIRE     = 3'd3;
    localparam logic [2:0] REQ_FLOOR      = 3'd4;
    localparam logic [2:0] REQ_CLASSIFY   = 3'd5;
    localparam logic [2:0] REQ_SHUTDOWN   = 3'd6;

    localparam logic [1:0] ST_UNKNOWN    = 2'd0;
    localparam logic [1:0] ST_ADMISSIBLE = 2'd1;
    localparam logic [1:0] ST_STALE      = 2'd2;

    localparam int unsigned IN_W  = 160;
    localparam int unsigned OUT_W = 96;
    localparam int unsigned ENT_W = 129;   // {stale, tag, config, epoch}
    localparam int unsigned RET_W = 64;    // {config, epoch}

    typedef struct packed {
        logic        stopped;
        logic        healthy;
        logic [31:0] failures;
        logic [31:0] floor_out;
        logic [4:0]  retired_count;
        logic [6:0]  stale_count;
        logic [6:0]  admissible_count;
        logic [1:0]  status;
        logic [6:0]  removed;
        logic        ok;
    } t_result;

    function automatic logic [6:0] sat7(input int unsigned v);
        return (v > 127) ? 7'd127 : v[6:0];
    endfunction

    function automatic logic [4:0] sat5(input int unsigned v);
        return (v > 31) ? 5'd31 : v[4:0];
    endfunction

endpackage

@@ design/epoch_retired_evidence_table_core.sv @@
// Epoch-retired evidence table: sequencer, valid bits, counters, output register.
// Depends on eretab_pkg and eretab_ram (proposal table and retired set).
//
// Each request runs through an accept step, a scan of the retired set one entry a
// cycle from its RAM and then a drain of the read pipeline, a scan of the proposal
// table the same way, and a final step that applies the update and loads the result
// register; the input is ready only in the idle state, so requests do not overlap.
// Writes to either RAM happen only in that final step, never during a scan, so a
// read and a write never touch the same entry together. Valid bits live in flip-flops
// and clear at reset; no clearing pass. A new request is taken while the previous
// result still waits to be taken.
module epoch_retired_evidence_table_core
    import eretab_pkg::*;
#(
    parameter int PROPOSAL_ENTRIES = 64,
    parameter int RETIRED_ENTRIES  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // epoch[31:0], config_tag[63:32], proposal_tag[127:64], new_floor[159:128]
    input  logic [IN_W-1:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]     s_axis_tuser,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // ok[0], removed[7:1], status[9:8], admissible_count[16:10],
    // stale_count[23:17], retired_count[28:24], floor_out[60:29],
    // failures[92:61], healthy_out[93], stopped_out[94], zero[95]
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [6:0]     i_cfg_data
);
    localparam int PAW = (PROPOSAL_ENTRIES > 1) ? $clog2(PROPOSAL_ENTRIES) : 1;
    localparam int RAW = (RETIRED_ENTRIES > 1) ? $clog2(RETIRED_ENTRIES) : 1;
    localparam int MAXD = (PROPOSAL_ENTRIES > RETIRED_ENTRIES) ?
                          PROPOSAL_ENTRIES : RETIRED_ENTRIES;
    localparam int CW  = $clog2(MAXD + 1);
    localparam int PCW = $clog2(PROPOSAL_ENTRIES + 1);
    localparam int RCW = $clog2(RETIRED_ENTRIES + 1);
    localparam int MW  = $clog2(PROPOSAL_ENTRIES + RETIRED_ENTRIES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RSCAN = 2'd1;
    localparam logic [1:0] S_PSCAN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [2:0]  r_req, n_req;
    logic [31:0] r_ep, n_ep, r_cf, n_cf, r_nf, n_nf;
    logic [63:0] r_tag, n_tag;
    logic [CW-1:0] r_cnt, n_cnt, r_pidx, n_pidx;
    logic        r_pend, n_pend;
    logic        r_dead, n_dead, r_found, n_found, r_fstale, n_fstale;
    logic [PAW-1:0] r_fidx, n_fidx, r_pfree, n_pfree;
    logic        r_phas, n_phas;
    logic [RAW-1:0] r_rfree, n_rfree;
    logic        r_rhas, n_rhas;
    logic        r_gofl, n_gofl;
    logic [MW-1:0] r_rem, n_rem;
    logic [PROPOSAL_ENTRIES-1:0] r_pvalid, n_pvalid;
    logic [RETIRED_ENTRIES-1:0]  r_rvalid, n_rvalid;
    logic [PCW-1:0] r_adm, n_adm, r_stl, n_stl;
    logic [RCW-1:0] r_rcnt, n_rcnt;
    logic [31:0] r_floor, n_floor, r_fail, n_fail;
    logic        r_healthy, n_healthy, r_stopped, n_stopped;
    logic [6:0]  r_plim, n_plim;
    logic [4:0]  r_rlim, n_rlim;
    logic        r_ovalid, n_ovalid;
    t_result     r_out, n_out;

    logic            p_we, rt_we;
    logic [PAW-1:0]  p_waddr;
    logic [ENT_W-1:0] p_wdata, p_rdata;
    logic [RAW-1:0]  rt_waddr;
    logic [RET_W-1:0] rt_wdata, rt_rdata;

    logic        go_ret, cap_ok, ins_ok, ins_fail, do_ins, ins_stale, do_stale;
    int unsigned plim_eff, rlim_eff;
    logic [PAW-1:0] pi;
    logic [RAW-1:0] ri;

    eretab_ram #(.W(ENT_W), .D(PROPOSAL_ENTRIES)) u_prop_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(r_cnt[PAW-1:0]), .o_rdata(p_rdata)
    );

    eretab_ram #(.W(RET_W), .D(RETIRED_ENTRIES)) u_ret_ram (
        .i_clk(i_clk), .i_we(rt_we), .i_waddr(rt_waddr), .i_wdata(rt_wdata),
        .i_raddr(r_cnt[RAW-1:0]), .o_rdata(rt_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_out};
    assign pi = r_pidx[PAW-1:0];
    assign ri = r_pidx[RAW-1:0];

    always_comb begin
        plim_eff = (32'(r_plim) > PROPOSAL_ENTRIES) ? PROPOSAL_ENTRIES : 32'(r_plim);
        rlim_eff = (32'(r_rlim) > RETIRED_ENTRIES) ? RETIRED_ENTRIES : 32'(r_rlim);
        go_ret = !r_stopped && !r_dead && r_healthy &&
                 (32'(r_rcnt) < rlim_eff) && r_rhas;
        cap_ok = (32'(r_adm) + 32'(r_stl) < plim_eff) && r_phas;
    end

    always_comb begin
        n_state = r_state; n_req = r_req; n_ep = r_ep; n_cf = r_cf; n_nf = r_nf;
        n_tag = r_tag; n_cnt = r_cnt; n_pidx = r_pidx; n_pend = r_pend;
        n_dead = r_dead; n_found = r_found; n_fstale = r_fstale; n_fidx = r_fidx;
        n_pfree = r_pfree; n_phas = r_phas; n_rfree = r_rfree; n_rhas = r_rhas;
        n_gofl = r_gofl; n_rem = r_rem; n_pvalid = r_pvalid; n_rvalid = r_rvalid;
        n_adm = r_adm; n_stl = r_stl; n_rcnt = r_rcnt; n_floor = r_floor;
        n_fail = r_fail; n_healthy = r_healthy; n_stopped = r_stopped;
        n_plim = r_plim; n_rlim = r_rlim; n_out = r_out;
        n_ovalid = r_ovalid && !m_axis_tready;
        p_we = 1'b0; p_waddr = r_pfree; p_wdata = {1'b0, r_tag, r_cf, r_ep};
        rt_we = 1'b0; rt_waddr = r_rfree; rt_wdata = {r_cf, r_ep};
        do_ins = 1'b0; ins_stale = 1'b0; do_stale = 1'b0;
        ins_ok = 1'b0; ins_fail = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req = s_axis_tuser;
                    n_ep  = s_axis_tdata[31:0];
                    n_cf  = s_axis_tdata[63:32];
                    n_tag = s_axis_tdata[127:64];
                    n_nf  = s_axis_tdata[159:128];
                    n_dead = s_axis_tdata[31:0] < r_floor;
                    n_gofl = (s_axis_tuser == REQ_FLOOR) && !r_stopped &&
                             (s_axis_tdata[159:128] > r_floor);
                    n_found = 1'b0; n_fstale = 1'b0; n_phas = 1'b0; n_rhas = 1'b0;
                    n_rem = '0; n_cnt = '0; n_pend = 1'b0;
                    n_state = S_RSCAN;
                end
            end
            S_RSCAN: begin
                n_pend = r_cnt < CW'(RETIRED_ENTRIES);
                if (r_cnt < CW'(RETIRED_ENTRIES)) begin
                    n_pidx = r_cnt;
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_pend) begin
                    if (!r_rvalid[ri]) begin
                        if (!r_rhas) begin
                            n_rhas = 1'b1;
                            n_rfree = ri;
                        end
                    end else if (r_gofl && rt_rdata[31:0] < r_nf) begin
                        n_rvalid[ri] = 1'b0;
                        n_rcnt = r_rcnt - 1'b1;
                        n_rem  = r_rem + 1'b1;
                    end else if (rt_rdata[31:0] == r_ep && rt_rdata[63:32] == r_cf) begin
                        n_dead = 1'b1;
                    end
                end
                if (r_cnt == CW'(RETIRED_ENTRIES) && !r_pend) begin
                    n_cnt = '0;
                    n_state = S_PSCAN;
                end
            end
            S_PSCAN: begin
                n_pend = r_cnt < CW'(PROPOSAL_ENTRIES);
                if (r_cnt < CW'(PROPOSAL_ENTRIES)) begin
                    n_pidx = r_cnt;
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_pend) begin
                    if (!r_pvalid[pi]) begin
                        if (!r_phas) begin
                            n_phas = 1'b1;
                            n_pfree = pi;
                        end
                    end else if ((r_gofl && p_rdata[31:0] < r_nf) ||
                                 (r_req == REQ_RETIRE && go_ret &&
                                  p_rdata[31:0] == r_ep && p_rdata[63:32] == r_cf)) begin
                        n_pvalid[pi] = 1'b0;
                        n_rem = r_rem + 1'b1;
                        if (p_rdata[128]) n_stl = r_stl - 1'b1;
                        else              n_adm = r_adm - 1'b1;
                    end else if (p_rdata[31:0] == r_ep && p_rdata[63:32] == r_cf &&
                                 p_rdata[127:64] == r_tag && !r_found) begin
                        n_found = 1'b1;
                        n_fidx = pi;
                        n_fstale = p_rdata[128];
                    end
                end
                if (r_cnt == CW'(PROPOSAL_ENTRIES) && !r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_out = '0;
                    unique case (r_req)
                        REQ_ADMIT: begin
                            if (!r_stopped && r_healthy && !r_dead) begin
                                if (r_found) n_out.ok = !r_fstale;
                                else do_ins = 1'b1;
                            end
                        end
                        REQ_STALE_IF: begin
                            if (!r_stopped && r_found && !r_fstale) do_stale = 1'b1;
                        end
                        REQ_MARK_STALE: begin
                            if (!r_stopped && !r_dead) begin
                                if (r_found) do_stale = !r_fstale;
                                else if (r_healthy) begin
                                    do_ins = 1'b1;
                                    ins_stale = 1'b1;
                                end
                            end
                        end
                        REQ_RETIRE: begin
                            if (go_ret) begin
                                rt_we = 1'b1;
                                n_rvalid[r_rfree] = 1'b1;
                                n_rcnt = r_rcnt + 1'b1;
                                n_out.ok = 1'b1;
                            end else if (!r_stopped && !r_dead && r_healthy) begin
                                ins_fail = 1'b1;
                            end
                        end
                        REQ_FLOOR: begin
                            if (r_gofl) begin
                                n_floor = r_nf;
                                n_out.ok = 1'b1;
                            end
                        end
                        REQ_CLASSIFY: begin
                            n_out.ok = 1'b1;
                            if (r_dead || (r_found && r_fstale)) n_out.status = ST_STALE;
                            else if (r_stopped || !r_healthy || !r_found)
                                n_out.status = ST_UNKNOWN;
                            else n_out.status = ST_ADMISSIBLE;
                        end
                        REQ_SHUTDOWN: begin
                            n_stopped = 1'b1;
                            n_out.ok = 1'b1;
                        end
                        default: ;
                    endcase
                    if (do_ins) begin
                        if (cap_ok) begin
                            ins_ok = 1'b1;
                            p_we = 1'b1;
                            p_wdata[128] = ins_stale;
                            n_pvalid[r_pfree] = 1'b1;
                            if (ins_stale) n_stl = r_stl + 1'b1;
                            else           n_adm = r_adm + 1'b1;
                            n_out.ok = 1'b1;
                        end else begin
                            ins_fail = 1'b1;
                        end
                    end
                    if (do_stale) begin
                        p_we = 1'b1;
                        p_waddr = r_fidx;
                        p_wdata[128] = 1'b1;
                        n_adm = r_adm - 1'b1;
                        n_stl = r_stl + 1'b1;
                        n_out.ok = 1'b1;
                    end
                    if (ins_fail) begin
                        n_healthy = 1'b0;
                        if (r_fail != '1) n_fail = r_fail + 1'b1;
                    end
                    n_out.removed = sat7(32'(r_rem));
                    n_out.admissible_count = sat7(32'(n_adm));
                    n_out.stale_count = sat7(32'(n_stl));
                    n_out.retired_count = sat5(32'(n_rcnt));
                    n_out.floor_out = n_floor;
                    n_out.failures = n_fail;
                    n_out.healthy = n_healthy;
                    n_out.stopped = n_stopped;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            if (i_cfg_idx) n_rlim = i_cfg_data[4:0];
            else           n_plim = i_cfg_data;
            if ((i_cfg_idx && i_cfg_data[4:0] == '0) || (!i_cfg_idx && i_cfg_data == '0))
                n_healthy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend <= 1'b0;
            r_cnt <= '0;
            r_pvalid <= '0;
            r_rvalid <= '0;
            r_adm <= '0;
            r_stl <= '0;
            r_rcnt <= '0;
            r_floor <= '0;
            r_fail <= '0;
            r_healthy <= 1'b1;
            r_stopped <= 1'b0;
            r_plim <= 7'd64;
            r_rlim <= 5'd16;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend <= n_pend;
            r_cnt <= n_cnt;
            r_pvalid <= n_pvalid;
            r_rvalid <= n_rvalid;
            r_adm <= n_adm;
            r_stl <= n_stl;
            r_rcnt <= n_rcnt;
            r_floor <= n_floor;
            r_fail <= n_fail;
            r_healthy <= n_healthy;
            r_stopped <= n_stopped;
            r_plim <= n_plim;
            r_rlim <= n_rlim;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_ep <= n_ep; r_cf <= n_cf; r_nf <= n_nf; r_tag <= n_tag;
        r_pidx <= n_pidx; r_dead <= n_dead; r_found <= n_found; r_fstale <= n_fstale;
        r_fidx <= n_fidx; r_pfree <= n_pfree; r_phas <= n_phas; r_rfree <= n_rfree;
        r_rhas <= n_rhas; r_gofl <= n_gofl; r_rem <= n_rem; r_out <= n_out;
    end

    a_entry_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_pvalid)) == 32'(r_adm) + 32'(r_stl))
        else $error("entry counters disagree with valid bits");
    a_retired_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_rvalid)) == 32'(r_rcnt))
        else $error("retired counter disagrees with valid bits");
    a_fail_unhealthy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fail != '0) |-> !r_healthy)
        else $error("failure recorded while healthy");
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (p_we || rt_we) |-> (r_state == S_FIN))
        else $error("table write outside update cycle");
endmodule

@@ design/eretab_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module eretab_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                       i_wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                       o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for epoch_retired_evidence_table_core: random and directed
// requests over the stream ports, an in-bench table predictor, field-by-field checks.
// Depends on eretab_pkg and the core RTL.
module tb
    import eretab_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROP = 64;
    localparam int NRET = 16;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  req;
        logic [31:0] epoch;
        logic [31:0] cfg;
        logic [63:0] tag;
        logic [31:0] nfloor;
    } t_req;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic i_cfg_we = 0;
    logic i_cfg_idx = 0;
    logic [6:0] i_cfg_data = '0;

    epoch_retired_evidence_table_core dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    bit          tv[NPROP];
    bit          tstale[NPROP];
    logic [31:0] tep[NPROP];
    logic [31:0] tcf[NPROP];
    logic [63:0] ttag[NPROP];
    bit          rv[NRET];
    logic [31:0] rep[NRET];
    logic [31:0] rcf[NRET];
    logic [31:0] floor_q;
    logic [31:0] fail_q;
    bit          healthy_q, stopped_q;
    int unsigned plim, rlim;

    t_req    pending[$];
    t_result expected_results[$];
    int      errors = 0;
    int      hold_off = 0;
    int      idle_cycles = 0;
    int      burst = 0, gap = 0;
    bit      pause_tx = 0;

    // key pools to make hits likely
    logic [31:0] ep_pool[8];
    logic [31:0] cf_pool[4];
    logic [63:0] tag_pool[8];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic void count_fail();
        if (fail_q != 32'hFFFF_FFFF) fail_q++;
        healthy_q = 0;
    endfunction

    function automatic bit insert_key(t_req r, bit st);
        int n = 0;
        int lim = (plim > NPROP) ? NPROP : plim;
        foreach (tv[i]) if (tv[i]) n++;
        if (n >= lim) begin
            count_fail();
            return 0;
        end
        foreach (tv[i]) if (!tv[i]) begin
            tv[i] = 1; tstale[i] = st; tep[i] = r.epoch; tcf[i] = r.cfg; ttag[i] = r.tag;
            return 1;
        end
        count_fail();
        return 0;
    endfunction

    function automatic t_result predict_table(t_req r);
        t_result o;
        bit dead;
        int idx = -1;
        int slot = -1;
        int rn = 0;
        int nrem = 0;
        int adm = 0, stl = 0;
        int lim;
        o = '0;
        dead = r.epoch < floor_q;
        foreach (rv[i]) if (rv[i] && rep[i] == r.epoch && rcf[i] == r.cfg) dead = 1;
        foreach (tv[i])
            if (idx < 0 && tv[i] && tep[i] == r.epoch && tcf[i] == r.cfg && ttag[i] == r.tag)
                idx = i;
        case (r.req)
            REQ_ADMIT: if (!stopped_q && healthy_q && !dead)
                o.ok = (idx >= 0) ? !tstale[idx] : insert_key(r, 0);
            REQ_STALE_IF: if (!stopped_q && idx >= 0 && !tstale[idx]) begin
                tstale[idx] = 1; o.ok = 1;
            end
            REQ_MARK_STALE: if (!stopped_q && !dead) begin
                if (idx >= 0) begin
                    if (!tstale[idx]) begin tstale[idx] = 1; o.ok = 1; end
                end else if (healthy_q) o.ok = insert_key(r, 1);
            end
            REQ_RETIRE: if (!stopped_q && !dead && healthy_q) begin
                lim = (rlim > NRET) ? NRET : rlim;
                foreach (rv[i]) begin
                    if (rv[i]) rn++;
                    else if (slot < 0) slot = i;
                end
                if (rn >= lim || slot < 0) count_fail();
                else begin
                    rv[slot] = 1; rep[slot] = r.epoch; rcf[slot] = r.cfg;
                    foreach (tv[i]) if (tv[i] && tep[i] == r.epoch && tcf[i] == r.cfg) begin
                        tv[i] = 0; nrem++;
                    end
                    o.ok = 1;
                end
            end
            REQ_FLOOR: if (!stopped_q && r.nfloor > floor_q) begin
                floor_q = r.nfloor;
                foreach (tv[i]) if (tv[i] && tep[i] < r.nfloor) begin tv[i] = 0; nrem++; end
                foreach (rv[i]) if (rv[i] && rep[i] < r.nfloor) begin rv[i] = 0; nrem++; end
                o.ok = 1;
            end
            REQ_CLASSIFY: begin
                if (dead || (idx >= 0 && tstale[idx])) o.status = ST_STALE;
                else if (stopped_q || !healthy_q || idx < 0) o.status = ST_UNKNOWN;
                else o.status = ST_ADMISSIBLE;
                o.ok = 1;
            end
            REQ_SHUTDOWN: begin stopped_q = 1; o.ok = 1; end
            default: ;
        endcase
        rn = 0;
        foreach (tv[i]) if (tv[i]) begin if (tstale[i]) stl++; else adm++; end
        foreach (rv[i]) if (rv[i]) rn++;
        o.removed = sat7(nrem);
        o.admissible_count = sat7(adm);
        o.stale_count = sat7(stl);
        o.retired_count = sat5(rn);
        o.floor_out = floor_q;
        o.failures = fail_q;
        o.healthy = healthy_q;
        o.stopped = stopped_q;
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap > 0) gap--;
            if (s_axis_tvalid && s_axis_tready) expected_results.push_back(predict_table(
                t_req'({s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                        s_axis_tdata[127:64], s_axis_tdata[159:128]})));
            if (pending.size() > 0 && gap == 0 && !pause_tx) begin
                t_req r;
                r = pending.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tuser <= r.req;
                s_axis_tdata <= {r.nfloor, r.tag, r.cfg, r.epoch};
                if (burst > 0) burst--;
                else begin
                    burst = $urandom_range(0, 6);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
                end
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // receiver stall pattern and monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result got, want;
            got = t_result'(m_axis_tdata[94:0]);
            if (expected_results.size() == 0) begin
                $display("mismatch: result with nothing expected");
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.ok !== want.ok) report("ok", got.ok, want.ok);
                if (got.removed !== want.removed) report("removed", got.removed, want.removed);
                if (got.status !== want.status) report("status", got.status, want.status);
                if (got.admissible_count !== want.admissible_count)
                    report("admissible", got.admissible_count, want.admissible_count);
                if (got.stale_count !== want.stale_count)
                    report("stale", got.stale_count, want.stale_count);
                if (got.retired_count !== want.retired_count)
                    report("retired", got.retired_count, want.retired_count);
                if (got.floor_out !== want.floor_out) report("floor", got.floor_out, want.floor_out);
                if (got.failures !== want.failures) report("failures", got.failures, want.failures);
                if (got.healthy !== want.healthy) report("healthy", got.healthy, want.healthy);
                if (got.stopped !== want.stopped) report("stopped", got.stopped, want.stopped);
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic t_req rand_req(input bit pooled);
        t_req r;
        r.req = $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
        if (pooled) begin
            r.epoch = ep_pool[$urandom_range(0, 7)];
            r.cfg = cf_pool[$urandom_range(0, 3)];
            r.tag = tag_pool[$urandom_range(0, 7)];
            r.nfloor = floor_q + $urandom_range(0, 3);
        end else begin
            r.epoch = $urandom;
            r.cfg = $urandom;
            r.tag = {$urandom, $urandom};
            r.nfloor = $urandom;
        end
        return r;
    endfunction

    task automatic key_req(input logic [2:0] q, input logic [31:0] e, input logic [31:0] c,
                           input logic [63:0] t, input logic [31:0] f);
        t_req r;
        r.req = q; r.epoch = e; r.cfg = c; r.tag = t; r.nfloor = f;
        pending.push_back(r);
    endtask

    task automatic drain();
        while (pending.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input bit idx, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == 0) plim = val; else rlim = val[4:0];
        if ((idx == 0 && val == 0) || (idx == 1 && val[4:0] == 0)) healthy_q = 0;
    endtask

    task automatic reset_model();
        foreach (tv[i]) tv[i] = 0;
        foreach (rv[i]) rv[i] = 0;
        floor_q = 0; fail_q = 0; healthy_q = 1; stopped_q = 0;
        plim = 64; rlim = 16;
    endtask

    task automatic run_random(input int n, input int base_ep);
        for (int i = 0; i < 8; i++) ep_pool[i] = base_ep + i;
        for (int i = 0; i < 4; i++) cf_pool[i] = $urandom;
        for (int i = 0; i < 8; i++) tag_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < n; i++) pending.push_back(rand_req($urandom_range(0, 5) != 0));
    endtask

    initial begin
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        // directed
        key_req(REQ_ADMIT, 32'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        key_req(REQ_ADMIT, 32'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        key_req(REQ_CLASSIFY, 32'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        key_req(REQ_STALE_IF, 32'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        key_req(REQ_STALE_IF, 32'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        key_req(REQ_ADMIT, 32'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        key_req(REQ_MARK_STALE, 32'hFFFF_FFFF, 32'd0, 64'd0, 0);
        key_req(REQ_CLASSIFY, 32'hFFFF_FFFF, 32'd0, 64'd0, 0);
        key_req(REQ_ADMIT, 32'd7, 32'd1, 64'd1, 0);
        key_req(REQ_ADMIT, 32'd7, 32'd1, 64'd2, 0);
        key_req(REQ_RETIRE, 32'd7, 32'd1, 64'd0, 0);
        key_req(REQ_ADMIT, 32'd7, 32'd1, 64'd1, 0);
        key_req(REQ_CLASSIFY, 32'd7, 32'd1, 64'd3, 0);
        key_req(REQ_FLOOR, 0, 0, 0, 32'd6);
        key_req(REQ_FLOOR, 0, 0, 0, 32'd6);
        key_req(REQ_CLASSIFY, 32'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        key_req(3'd7, 32'd9, 32'd9, 64'd9, 32'd9);
        key_req(REQ_FLOOR, 0, 0, 0, 32'd0);
        drain();
        // small limits: capacity failures
        write_reg(0, 7'd2);
        write_reg(1, 7'd1);
        key_req(REQ_ADMIT, 32'd10, 32'd0, 64'd1, 0);
        key_req(REQ_MARK_STALE, 32'd10, 32'd0, 64'd2, 0);
        key_req(REQ_ADMIT, 32'd10, 32'd0, 64'd3, 0);
        key_req(REQ_RETIRE, 32'd11, 32'd0, 64'd0, 0);
        key_req(REQ_RETIRE, 32'd12, 32'd0, 64'd0, 0);
        drain();
        write_reg(0, 7'd127);
        write_reg(1, 7'd31);
        run_random(60, 100);
        // long receiver hold-off while sender keeps offering
        hold_off = 3000;
        drain();
        write_reg(0, 7'd0);
        write_reg(1, 7'd0);
        run_random(40, 200);
        drain();
        // fresh limits via reset-equivalent values; health stays off, so vary anyway
        write_reg(0, 7'd64);
        write_reg(1, 7'd16);
        run_random(150, 300);
        // sender pauses midway until every outstanding result is back
        while (pending.size() > 75) @(posedge i_clk);
        pause_tx = 1;
        while (s_axis_tvalid || expected_results.size() > 0) @(posedge i_clk);
        pause_tx = 0;
        drain();
        write_reg(0, 7'd8);
        write_reg(1, 7'd3);
        run_random(156, 400);
        key_req(REQ_SHUTDOWN, 0, 0, 0, 0);
        run_random(20, 400);
        drain();
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
